### rtl/uirb_pkg.sv
// Shared types and constants for the UART interrupt ring buffers.
// No dependencies; imported by uirb_ring and uart_interrupt_ring_buffers.
`default_nettype none

package uirb_pkg;

    typedef enum logic [1:0] {
        OP_RX_BYTE  = 2'd0,
        OP_TX_READY = 2'd1,
        OP_APP_READ = 2'd2,
        OP_APP_WRITE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_RX_DROPPED = 3'd1,
        ST_RX_EMPTY   = 3'd2,
        ST_TX_FULL    = 3'd3,
        ST_TX_IDLE    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_LF   = 3'b100
    } t_state;

    // occupancy flags of one ring
    typedef struct packed {
        logic empty;
        logic no_room1;   // fewer than one free slot
        logic no_room2;   // fewer than two free slots
    } t_ring_stat;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

endpackage

`default_nettype wire

### rtl/uirb_ring.sv
// One circular byte ring: synchronous memory plus read/write pointers.
// Depends on uirb_pkg (t_ring_stat).
`default_nettype none

module uirb_ring
    import uirb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_push_data,
    input  wire logic       i_pop,
    output t_ring_stat      o_stat,
    output logic [7:0]      o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [7:0]       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr, wr_next2;
    logic [7:0]       r_pop_data;

    assign n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
    assign wr_next2 = (n_wr_ptr == LAST) ? '0 : n_wr_ptr + 1'b1;

    assign o_stat.empty    = (r_wr_ptr == r_rd_ptr);
    assign o_stat.no_room1 = (n_wr_ptr == r_rd_ptr);
    assign o_stat.no_room2 = (n_wr_ptr == r_rd_ptr) || (wr_next2 == r_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    // push and pop never hit the same entry in one cycle: a pop only
    // reads a filled entry, never the one at the write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
        if (i_pop) begin
            r_pop_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_pop_data = r_pop_data;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.no_room1))
        else $error("push into full ring");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from empty ring");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_stat.empty)
        else $error("ring empty after push");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wr_ptr} < (PTR_W+1)'(DEPTH)) && ({1'b0, r_rd_ptr} < (PTR_W+1)'(DEPTH)))
        else $error("ring pointer out of range");

endmodule

`default_nettype wire

### rtl/uart_interrupt_ring_buffers.sv
// UART interrupt ring buffers: receive and transmit byte rings with IRQ enables.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation word: op and
//   data byte. Ops: received byte, transmit ready, application read,
//   application write. Output channel (o_out_valid / i_out_ready) returns one
//   word per operation: popped byte, status and both interrupt enables.
//   Each ring holds RING_DEPTH-1 bytes; a newline write stores CR then LF.
// Accept and result flow:
//   Pushes and refused/empty ops: result registered on accept; a new word is
//   taken while it waits in the output register if the receiver drains it.
//   Successful pops: memory read is registered, then S_POP loads the output;
//   one write port takes newline CR, then LF in S_LF; S_POP and S_LF take no word.
// Reset: pointers and both enables clear; ring contents are not cleared, so
//   there is no startup sweep and the block is ready right after reset.
// Stall: a finished word waits in the output register; a new word is taken
//   in the cycle the receiver drains it, and none while it is held.
// Depends on uirb_pkg and uirb_ring.
`default_nettype none

module uart_interrupt_ring_buffers
    import uirb_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_byte_out,
    output logic [2:0]      o_status,
    output logic            o_rx_irq_enable,
    output logic            o_tx_irq_enable
);

    t_state     r_state, n_state;
    t_ring_stat rx_stat, tx_stat;
    logic [7:0] rx_pop_data, tx_pop_data;
    logic       accept, is_lf;
    t_op        op;
    logic       rx_push, rx_pop, tx_push, tx_pop;
    logic [7:0] tx_push_data;
    logic       r_rx_en, r_tx_en, n_rx_en, n_tx_en;
    t_status    r_status, n_status;
    logic [7:0] r_byte_out;
    logic       r_out_valid, n_out_valid;
    logic       r_pop_tx;

    assign op     = t_op'(i_op);
    assign is_lf  = (i_data_byte == BYTE_LF);
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept = i_in_valid && o_in_ready;

    assign rx_push = accept && (op == OP_RX_BYTE) && !rx_stat.no_room1;
    assign rx_pop  = accept && (op == OP_APP_READ) && !rx_stat.empty;
    assign tx_pop  = accept && (op == OP_TX_READY) && !tx_stat.empty;
    assign tx_push = (accept && (op == OP_APP_WRITE)
                      && !(is_lf ? tx_stat.no_room2 : tx_stat.no_room1))
                     || (r_state == S_LF);
    assign tx_push_data = (r_state == S_LF) ? BYTE_LF : (is_lf ? BYTE_CR : i_data_byte);

    uirb_ring #(.DEPTH(RING_DEPTH)) u_rx_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (rx_push),
        .i_push_data (i_data_byte),
        .i_pop       (rx_pop),
        .o_stat      (rx_stat),
        .o_pop_data  (rx_pop_data)
    );

    uirb_ring #(.DEPTH(RING_DEPTH)) u_tx_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (tx_push),
        .i_push_data (tx_push_data),
        .i_pop       (tx_pop),
        .o_stat      (tx_stat),
        .o_pop_data  (tx_pop_data)
    );

    always_comb begin
        n_rx_en  = r_rx_en;
        n_tx_en  = r_tx_en;
        n_status = ST_OK;
        case (op)
            OP_RX_BYTE: begin
                if (rx_stat.no_room1) begin
                    n_rx_en  = 1'b0;
                    n_status = ST_RX_DROPPED;
                end
            end
            OP_TX_READY: begin
                n_tx_en = !tx_stat.empty;
                if (tx_stat.empty) begin
                    n_status = ST_TX_IDLE;
                end
            end
            OP_APP_READ: begin
                if (rx_stat.empty) begin
                    n_rx_en  = 1'b1;
                    n_status = ST_RX_EMPTY;
                end
            end
            OP_APP_WRITE: begin
                n_tx_en = 1'b1;
                if (is_lf ? tx_stat.no_room2 : tx_stat.no_room1) begin
                    n_status = ST_TX_FULL;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (rx_pop || tx_pop) begin
                        n_state     = S_POP;
                        n_out_valid = 1'b0;
                    end else begin
                        n_out_valid = 1'b1;
                        if (tx_push && is_lf) begin
                            n_state = S_LF;
                        end
                    end
                end
            end
            S_POP: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            S_LF: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rx_en     <= 1'b0;
            r_tx_en     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_rx_en <= n_rx_en;
                r_tx_en <= n_tx_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_byte_out <= '0;
            r_pop_tx   <= tx_pop;
        end else if (r_state == S_POP) begin
            r_byte_out <= r_pop_tx ? tx_pop_data : rx_pop_data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_out      = r_byte_out;
    assign o_status        = r_status;
    assign o_rx_irq_enable = r_rx_en;
    assign o_tx_irq_enable = r_tx_en;

endmodule

`default_nettype wire
